// ===== hdl/tme_pkg.sv =====
// ----------------------------------------------------------------------------
// tme_pkg: shared types and constants for the tape machine executor
// Tape size, opcode codes, channel item types and the control/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tme_pkg;

    // Tape geometry
    localparam int TAPE_DEPTH = 65536;
    localparam int HEAD_W     = $clog2(TAPE_DEPTH);

    // Opcodes
    localparam logic [4:0] OP_INC    = 5'd0;
    localparam logic [4:0] OP_DEC    = 5'd1;
    localparam logic [4:0] OP_LEFT   = 5'd2;
    localparam logic [4:0] OP_RIGHT  = 5'd3;
    localparam logic [4:0] OP_OUT    = 5'd4;
    localparam logic [4:0] OP_IN     = 5'd5;
    localparam logic [4:0] OP_BEGIN  = 5'd6;
    localparam logic [4:0] OP_END    = 5'd7;
    localparam logic [4:0] OP_ADD    = 5'd8;
    localparam logic [4:0] OP_SUB    = 5'd9;
    localparam logic [4:0] OP_MVL    = 5'd10;
    localparam logic [4:0] OP_MVR    = 5'd11;
    localparam logic [4:0] OP_SET    = 5'd12;
    localparam logic [4:0] OP_ADDOFF = 5'd13;
    localparam logic [4:0] OP_SUBOFF = 5'd14;
    localparam logic [4:0] OP_SETOFF = 5'd15;
    localparam logic [4:0] OP_MULT   = 5'd16;

    // One instruction request
    typedef struct packed {
        logic [4:0] cmd;
        logic [7:0] arg_first;
        logic [7:0] arg_second;
        logic [7:0] in_byte;
    } t_in_item;

    // One result request
    typedef struct packed {
        logic        jump_taken;
        logic [15:0] jump_target;
        logic        out_valid;
        logic [7:0]  out_byte;
        logic        bad_opcode;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_we;
        logic accept;
        logic exec;
        logic mac;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic is_mult;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== hdl/tme_in_if.sv =====
// ----------------------------------------------------------------------------
// tme_in_if: instruction channel
// Valid/ready channel carrying one instruction request per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tme_in_if;
    import tme_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/tme_out_if.sv =====
// ----------------------------------------------------------------------------
// tme_out_if: result channel
// Valid/ready channel carrying one result request per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tme_out_if;
    import tme_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/tme_ctl.sv =====
// ----------------------------------------------------------------------------
// tme_ctl: executor controller
// Sequences the tape clear after reset and the read/execute/accumulate
// steps of each instruction, and owns both channel handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tme_ctl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output tme_pkg::t_dp_cmd      o_cmd,
    input  wire tme_pkg::t_dp_sts i_sts
);
    import tme_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;
    localparam logic [1:0] ST_MAC   = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_full, n_full;
    logic       w_accept;

    // Take a request only when idle and the result slot is free or draining
    assign o_in_ready  = (r_state == ST_IDLE) && (!r_full || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_full;

    // Drive datapath commands
    always_comb begin
        o_cmd.clear_we = (r_state == ST_CLEAR);
        o_cmd.accept   = w_accept;
        o_cmd.exec     = (r_state == ST_EXEC);
        o_cmd.mac      = (r_state == ST_MAC);
        o_cmd.load_out = ((r_state == ST_EXEC) && !i_sts.is_mult) || (r_state == ST_MAC);
    end

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clear_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = i_sts.is_mult ? ST_MAC : ST_IDLE;
            end
            ST_MAC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold the result slot until the sink takes it
    always_comb begin
        n_full = r_full;
        if (o_cmd.load_out) begin
            n_full = 1'b1;
        end else if (r_full && i_out_ready) begin
            n_full = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_full  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_full  <= n_full;
        end
    end

    // A new result never lands on one still waiting
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> !r_full)
        else $error("result loaded while slot occupied");

    // An accepted request is executed in the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_EXEC))
        else $error("accepted request not executed");

    // Accumulate step only follows an execute step of a multiply
    a_mac_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> ($past(r_state) == ST_EXEC && $past(i_sts.is_mult)))
        else $error("accumulate step out of order");

endmodule

`default_nettype wire

// ===== hdl/tme_dp.sv =====
// ----------------------------------------------------------------------------
// tme_dp: executor datapath
// Single-port tape memory, head pointer, wrap adder for head moves and
// offset addressing, cell arithmetic and the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module tme_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tme_pkg::t_dp_cmd   i_cmd,
    output tme_pkg::t_dp_sts        o_sts,
    input  wire tme_pkg::t_in_item  i_in_data,
    output tme_pkg::t_out_item      o_out_data
);
    import tme_pkg::*;

    localparam logic signed [HEAD_W+1:0] DEPTH_S = (HEAD_W+2)'(TAPE_DEPTH);
    localparam logic [HEAD_W:0]          DEPTH_U = (HEAD_W+1)'(TAPE_DEPTH);
    localparam logic [HEAD_W-1:0]        LAST_ADDR = HEAD_W'(TAPE_DEPTH - 1);

    // Add a signed step to a tape position, modulo the tape size
    function automatic logic [HEAD_W-1:0] f_wrap(input logic [HEAD_W-1:0] base,
                                                  input logic signed [8:0] delta);
        logic signed [HEAD_W+1:0] s;
        s = $signed({2'b00, base}) + $signed({{(HEAD_W-7){delta[8]}}, delta});
        if (s < 0) begin
            s = s + DEPTH_S;
        end else if (s >= DEPTH_S) begin
            s = s - DEPTH_S;
        end
        return s[HEAD_W-1:0];
    endfunction

    logic [7:0]        r_tape [TAPE_DEPTH];
    logic [7:0]        r_rdata;
    logic [4:0]        r_op;
    logic [7:0]        r_arg_a;
    logic [7:0]        r_arg_b;
    logic [7:0]        r_in_byte;
    logic [HEAD_W-1:0] r_addr;
    logic [HEAD_W-1:0] r_head;
    logic [HEAD_W-1:0] r_clr_addr;
    logic [7:0]        r_prod;
    t_out_item         r_out;

    logic signed [8:0] w_delta;
    logic [HEAD_W-1:0] w_wrap;
    logic              w_in_off;
    logic              w_is_mult;
    logic              w_is_move;
    logic [HEAD_W-1:0] w_mem_addr;
    logic              w_mem_we;
    logic [7:0]        w_mem_wdata;
    logic              w_cell_we;
    logic [7:0]        w_cell_new;
    logic [15:0]       w_prod;
    t_out_item         w_res;

    assign w_is_mult = (r_op == OP_MULT);
    assign w_in_off  = (i_in_data.cmd == OP_ADDOFF) || (i_in_data.cmd == OP_SUBOFF) ||
                       (i_in_data.cmd == OP_SETOFF);
    assign w_is_move = (r_op == OP_LEFT) || (r_op == OP_RIGHT) ||
                       (r_op == OP_MVL) || (r_op == OP_MVR);

    // Select the step for the shared wrap adder
    always_comb begin
        if (i_cmd.accept) begin
            w_delta = $signed({i_in_data.arg_first[7], i_in_data.arg_first});
        end else begin
            case (r_op)
                OP_LEFT:  w_delta = -9'sd1;
                OP_RIGHT: w_delta = 9'sd1;
                OP_MVL:   w_delta = -$signed({1'b0, r_arg_a});
                OP_MVR:   w_delta = $signed({1'b0, r_arg_a});
                default:  w_delta = $signed({r_arg_a[7], r_arg_a});
            endcase
        end
    end

    assign w_wrap = f_wrap(r_head, w_delta);

    // Compute the updated current cell for single-read opcodes
    always_comb begin
        w_cell_we  = 1'b1;
        w_cell_new = r_rdata;
        case (r_op)
            OP_INC:    w_cell_new = r_rdata + 8'd1;
            OP_DEC:    w_cell_new = r_rdata - 8'd1;
            OP_IN:     w_cell_new = r_in_byte;
            OP_ADD:    w_cell_new = r_rdata + r_arg_a;
            OP_SUB:    w_cell_new = r_rdata - r_arg_a;
            OP_SET:    w_cell_new = r_arg_a;
            OP_ADDOFF: w_cell_new = r_rdata + r_arg_b;
            OP_SUBOFF: w_cell_new = r_rdata - r_arg_b;
            OP_SETOFF: w_cell_new = r_arg_b;
            default:   w_cell_we  = 1'b0;
        endcase
    end

    assign w_prod = r_rdata * r_arg_b;

    // Memory port: clear sweep, request read, multiply second read, write back
    always_comb begin
        if (i_cmd.clear_we) begin
            w_mem_addr = r_clr_addr;
        end else if (i_cmd.accept) begin
            w_mem_addr = w_in_off ? w_wrap : r_head;
        end else if (i_cmd.exec && w_is_mult) begin
            w_mem_addr = w_wrap;
        end else begin
            w_mem_addr = r_addr;
        end
        w_mem_we    = i_cmd.clear_we || (i_cmd.exec && w_cell_we) || i_cmd.mac;
        w_mem_wdata = i_cmd.clear_we ? 8'd0 : (i_cmd.mac ? (r_rdata + r_prod) : w_cell_new);
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_tape[w_mem_addr] <= w_mem_wdata;
        r_rdata <= r_tape[w_mem_addr];
    end

    // Build the result from the current cell
    always_comb begin
        w_res             = '0;
        w_res.bad_opcode  = (r_op > OP_MULT);
        w_res.out_valid   = (r_op == OP_OUT);
        w_res.out_byte    = (r_op == OP_OUT) ? r_rdata : 8'd0;
        w_res.jump_taken  = ((r_op == OP_BEGIN) && (r_rdata == 8'd0)) ||
                            ((r_op == OP_END) && (r_rdata != 8'd0));
        w_res.jump_target = w_res.jump_taken ? {r_arg_a, r_arg_b} : 16'd0;
    end

    // Latch request fields and working values
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op      <= i_in_data.cmd;
            r_arg_a   <= i_in_data.arg_first;
            r_arg_b   <= i_in_data.arg_second;
            r_in_byte <= i_in_data.in_byte;
            r_addr    <= w_in_off ? w_wrap : r_head;
        end else if (i_cmd.exec && w_is_mult) begin
            r_addr    <= w_wrap;
        end
        if (i_cmd.exec) r_prod <= w_prod[7:0];
        if (i_cmd.load_out) r_out <= w_res;
    end

    // Advance the head and the clear sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.exec && w_is_move) r_head <= w_wrap;
            if (i_cmd.clear_we) r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_sts.clear_last = (r_clr_addr == LAST_ADDR);
    assign o_sts.is_mult    = w_is_mult;
    assign o_out_data       = r_out;

    // Head stays on the tape
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_head} < DEPTH_U)
        else $error("head outside tape");

endmodule

`default_nettype wire

// ===== hdl/tape_machine_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// tape_machine_instruction_executor: optimized tape machine instruction core
// Executes one instruction request against a byte tape and a head pointer
// and returns one result request per instruction.
//
// Channels: i_in (sink) takes opcode, two argument bytes and an input byte;
// o_out (source) gives jump flag/target, output flag/byte and bad opcode.
// A request moves on a rising edge with valid and ready both high.
// Steps: an accepted request executes in the next cycle, which registers the
// result; multiply-accumulate adds an accumulate step that registers it. A new
// request is taken only after the last is done, as set by the single tape
// memory port (multiply-accumulate reads two cells) and the registered read data.
// Reset: the head returns to zero and the controller sweeps the tape to zero,
// one cell a cycle, TAPE_DEPTH cells (65536); i_in.ready stays low meanwhile.
// Stall: a finished result waits in the output register and the next request
// is held until the result is taken; it may be taken in that same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tape_machine_instruction_executor (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tme_in_if.sink     i_in,
    tme_out_if.source  o_out
);
    import tme_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;
    logic    w_out_valid;

    // Sequence each instruction
    tme_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // Tape, head and arithmetic
    tme_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_in_data  (i_in.data),
        .o_out_data (o_out.data)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

endmodule

`default_nettype wire
